// ===== hdl/arlm_pkg.sv =====
// Shared constants, types and state codes for the audio RMS level meter.
`timescale 1ns / 1ps
package arlm_pkg;
	localparam int BLOCK_LEN_DEF   = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 16;
	localparam int RMS_W    = 16;
	localparam int SMOOTH_W = 24;
	localparam int GAIN_W   = 16;

	localparam logic [GAIN_W-1:0] GAIN_OLD = 16'd52429;
	localparam logic [GAIN_W-1:0] GAIN_NEW = 16'd13107;
	localparam logic [RMS_W:0]    RMS_MAX  = 17'd32768;

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_TICK   = 1'b1
	} req_type_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_ROOT,
		ST_SMOOTH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;
endpackage

// ===== hdl/audio_rms_level_meter.sv =====
// Audio RMS level meter: per-block RMS of squared samples with one-pole smoothing.
// A sample transaction runs the serial squarer and then an accumulate step, and the last
// sample of a block also runs the serial square root.
// An update tick runs the serial smoother and then loads the output register.
// One item is in work at a time; a result still waiting for the sink holds the next tick,
// and with it the input, in its final cycle until the result leaves.
// Reset clears the sum, sample count, block RMS and smoothed level to zero.
`timescale 1ns / 1ps
module audio_rms_level_meter import arlm_pkg::*; #(
	parameter int BLOCK_LEN   = BLOCK_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic signed [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
	input  logic                       s_tuser,   // [0] req_type
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [LEVEL_W-1:0]         m_tdata    // [15:0] level
);
	localparam int LOG2_LEN = $clog2(BLOCK_LEN);
	localparam int SQ_W     = 2 * SAMPLE_BITS;
	localparam int SUM_W    = SQ_W - 1 + LOG2_LEN;
	localparam int EXT_W    = SMOOTH_W - LEVEL_W;

	state_t state_q, state_d;

	logic [SUM_W-1:0]       sum_q;
	logic [LOG2_LEN-1:0]    count_q;
	logic [RMS_W-1:0]       block_rms_q;
	logic [SMOOTH_W-1:0]    smoothed_q;
	logic                   out_valid_q;
	logic [LEVEL_W-1:0]     out_data_q;

	logic                   in_fire;
	logic                   sq_start;
	logic                   rt_start;
	logic                   sm_start;
	logic                   emit;
	logic                   block_end;
	logic [SAMPLE_BITS-1:0] sample_v;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SQ_W-1:0]        square;
	logic [SAMPLE_BITS-1:0] root;
	logic [RMS_W:0]         rms_wide;
	logic [RMS_W-1:0]       rms_sat;
	logic [SMOOTH_W-1:0]    sm_out;
	unit_sts_t              sq_sts;
	unit_sts_t              rt_sts;
	unit_sts_t              sm_sts;

	generate
		if (SAMPLE_BITS <= SAMPLE_W) begin : g_narrow
			assign sample_v = s_tdata[SAMPLE_BITS-1:0];
		end else begin : g_wide
			assign sample_v = SAMPLE_BITS'(s_tdata);
		end
		if (SAMPLE_BITS >= RMS_W) begin : g_rms_down
			assign rms_wide = (RMS_W + 1)'(root >> (SAMPLE_BITS - RMS_W));
		end else begin : g_rms_up
			assign rms_wide = (RMS_W + 1)'(root) << (RMS_W - SAMPLE_BITS);
		end
	endgenerate

	// Negating the most negative code wraps to the same pattern, which reads as its magnitude.
	assign mag     = sample_v[SAMPLE_BITS-1] ? (~sample_v + 1'b1) : sample_v;
	assign rms_sat = (rms_wide > RMS_MAX) ? RMS_MAX[RMS_W-1:0] : rms_wide[RMS_W-1:0];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign block_end = (count_q == LOG2_LEN'(BLOCK_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		rt_start = 1'b0;
		sm_start = 1'b0;
		emit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (req_type_t'(s_tuser) == REQ_TICK) begin
						sm_start = 1'b1;
						state_d  = ST_SMOOTH;
					end else begin
						sq_start = 1'b1;
						state_d  = ST_SQUARE;
					end
				end
			end
			ST_SQUARE: begin
				if (sq_sts.done) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				if (block_end) begin
					rt_start = 1'b1;
					state_d  = ST_ROOT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ROOT: begin
				if (rt_sts.done) begin
					state_d = ST_IDLE;
				end
			end
			ST_SMOOTH: begin
				if (sm_sts.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || m_tready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			block_rms_q <= '0;
			smoothed_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SQUARE && sq_sts.done) begin
				sum_q <= sum_q + SUM_W'(square);
			end
			// The root unit has latched the mean, so the block can restart at once.
			if (state_q == ST_ACCUM) begin
				if (block_end) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == ST_ROOT && rt_sts.done) begin
				block_rms_q <= rms_sat;
			end
			if (state_q == ST_SMOOTH && sm_sts.done) begin
				smoothed_q <= sm_out;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= smoothed_q[SMOOTH_W-1:EXT_W];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	arlm_square #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_square (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.mag    (mag),
		.sts    (sq_sts),
		.square (square)
	);

	arlm_isqrt #(
		.OUT_W(SAMPLE_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rt_start),
		.radicand ({1'b0, sum_q[SUM_W-1:LOG2_LEN]}),
		.sts      (rt_sts),
		.root     (root)
	);

	arlm_smooth u_smooth (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (sm_start),
		.level_in  (smoothed_q),
		.rms_in    (block_rms_q),
		.sts       (sm_sts),
		.level_out (sm_out)
	);

	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!sq_sts.busy && !rt_sts.busy && !sm_sts.busy))
		else $error("serial unit busy while the block accepts input");

	a_rms_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, block_rms_q} <= RMS_MAX))
		else $error("block RMS above full scale");

	a_smooth_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sm_sts.done |-> (state_q == ST_SMOOTH))
		else $error("smoother finished outside its state");

	a_count_moves_in_accum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ACCUM) |=> $stable(count_q))
		else $error("sample count changed outside the accumulate step");
endmodule

// ===== hdl/arlm_square.sv =====
// Bit-serial squarer: one multiplier bit per cycle, shift-right product register.
`timescale 1ns / 1ps
module arlm_square import arlm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [SAMPLE_BITS-1:0]     mag,
	output unit_sts_t                  sts,
	output logic [2*SAMPLE_BITS-1:0]   square
);
	localparam int CNT_W = $clog2(SAMPLE_BITS);

	logic [SAMPLE_BITS-1:0]   mcand_q;
	logic [2*SAMPLE_BITS-1:0] prod_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [SAMPLE_BITS:0]     hi_sum;

	// The upper half gains the multiplicand when the bit leaving at the bottom is set.
	always_comb begin
		hi_sum = {1'b0, prod_q[2*SAMPLE_BITS-1:SAMPLE_BITS]};
		if (prod_q[0]) begin
			hi_sum = hi_sum + {1'b0, mcand_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SAMPLE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mag;
			prod_q  <= {{SAMPLE_BITS{1'b0}}, mag};
		end else if (busy_q) begin
			prod_q <= {hi_sum, prod_q[SAMPLE_BITS-1:1]};
		end
	end

	assign sts    = '{busy: busy_q, done: done_q};
	assign square = prod_q;
endmodule

// ===== hdl/arlm_isqrt.sv =====
// Digit-serial floor square root: two radicand bits and one root bit per cycle.
`timescale 1ns / 1ps
module arlm_isqrt import arlm_pkg::*; #(
	parameter int OUT_W = SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2*OUT_W-1:0]   radicand,
	output unit_sts_t            sts,
	output logic [OUT_W-1:0]     root
);
	localparam int IN_W  = 2 * OUT_W;
	localparam int REM_W = OUT_W + 2;
	localparam int CNT_W = $clog2(OUT_W);

	logic [IN_W-1:0]  rad_q;
	logic [REM_W-1:0] rem_q;
	logic [OUT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             fits;

	// The partial remainder never exceeds twice the partial root, so its top bits are free.
	always_comb begin
		rem_sh = {rem_q[OUT_W-1:0], rad_q[IN_W-1:IN_W-2]};
		trial  = {root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(OUT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[IN_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[OUT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[OUT_W-2:0], 1'b0};
			end
		end
	end

	assign sts  = '{busy: busy_q, done: done_q};
	assign root = root_q;
endmodule

// ===== hdl/arlm_smooth.sv =====
// Bit-serial one-pole smoother: walks the two gain constants one bit per cycle.
`timescale 1ns / 1ps
module arlm_smooth import arlm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SMOOTH_W-1:0] level_in,
	input  logic [RMS_W-1:0]    rms_in,
	output unit_sts_t           sts,
	output logic [SMOOTH_W-1:0] level_out
);
	localparam int ACC_W  = SMOOTH_W + 2;
	localparam int EXT_W  = SMOOTH_W - RMS_W;
	localparam int CNT_W  = $clog2(GAIN_W);

	logic [SMOOTH_W-1:0] old_q;
	logic [RMS_W-1:0]    rms_q;
	logic [ACC_W-1:0]    acc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ACC_W-1:0]    sum;

	// Shifting the running sum right after each gain bit keeps the floor of the full product.
	always_comb begin
		sum = acc_q;
		if (GAIN_OLD[cnt_q]) begin
			sum = sum + ACC_W'(old_q);
		end
		if (GAIN_NEW[cnt_q]) begin
			sum = sum + ACC_W'({rms_q, {EXT_W{1'b0}}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			old_q <= level_in;
			rms_q <= rms_in;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {1'b0, sum[ACC_W-1:1]};
		end
	end

	assign sts       = '{busy: busy_q, done: done_q};
	assign level_out = acc_q[SMOOTH_W-1:0];
endmodule
